>>> hdl/ww_pkg.sv
// ----------------------------------------------------------------------------
// ww_pkg
// Shared types and constants for the WireWorld generation step.
// ----------------------------------------------------------------------------
package ww_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // input row counter saturates here
  localparam int ROW_CNT_W = 12;
  localparam int ROW_SAT   = 4095;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 11;

  localparam int OBUF_DEPTH = 3;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_TAIL  = 2'd1,
    CELL_HEAD  = 2'd2,
    CELL_COND  = 2'd3
  } cell_t;

  typedef enum logic {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_CLEAR = 1'b0,
    MODE_RUN   = 1'b1
  } mode_t;

  typedef logic [1:0] obuf_ptr_t;
  typedef logic [1:0] obuf_cnt_t;

  // control carried from the accept stage to the window stage
  typedef struct packed {
    cell_t cur;
    logic  row_zero;
    logic  col_zero;
    logic  emit;
    logic  last;
  } stage_ctl_t;

  typedef struct packed {
    cell_t up;
    cell_t mid;
    cell_t cur;
    logic  col_zero;
  } win_in_t;

  typedef struct packed {
    cell_t next_state;
    logic  head_born;
  } rule_out_t;

  typedef struct packed {
    cell_t next_state;
    logic  head_born;
    logic  frame_end;
    logic  frame_any_born;
  } result_t;

endpackage

>>> hdl/ww_window.sv
// ----------------------------------------------------------------------------
// ww_window
// 3x3 neighbourhood window and WireWorld rule for the centre cell.
// ----------------------------------------------------------------------------
module ww_window import ww_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  win_in_t   win_in,
  output rule_out_t rule_out
);

  // only the left and centre columns are kept; the right one comes straight from the input
  cell_t     mc_r [3];
  cell_t     rc_r [3];
  cell_t     col_new [3];
  cell_t     right [3];
  logic [3:0] heads;

  always_comb begin
    col_new[0] = win_in.up;
    col_new[1] = win_in.mid;
    col_new[2] = win_in.cur;
    heads = '0;
    for (int i = 0; i < 3; i++) begin
      right[i] = win_in.col_zero ? CELL_EMPTY : col_new[i];
      heads = heads + 4'(mc_r[i] == CELL_HEAD) + 4'(right[i] == CELL_HEAD);
    end
    heads = heads + 4'(rc_r[0] == CELL_HEAD) + 4'(rc_r[2] == CELL_HEAD);

    rule_out.next_state = rc_r[1];
    rule_out.head_born  = 1'b0;
    unique case (rc_r[1])
      CELL_HEAD: rule_out.next_state = CELL_TAIL;
      CELL_TAIL: rule_out.next_state = CELL_COND;
      CELL_COND: begin
        if (heads == 4'd1 || heads == 4'd2) begin
          rule_out.next_state = CELL_HEAD;
          rule_out.head_born  = 1'b1;
        end
      end
      CELL_EMPTY: rule_out.next_state = CELL_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mc_r[i] <= CELL_EMPTY;
        rc_r[i] <= CELL_EMPTY;
      end
    end else if (step) begin
      // a new row starts with empty cells to its left
      for (int i = 0; i < 3; i++) begin
        mc_r[i] <= win_in.col_zero ? CELL_EMPTY : rc_r[i];
        rc_r[i] <= col_new[i];
      end
    end
  end

endmodule

>>> hdl/ww_out_buf.sv
// ----------------------------------------------------------------------------
// ww_out_buf
// Small result queue between the window stage and the output channel.
// ----------------------------------------------------------------------------
module ww_out_buf import ww_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   push_data,
  output logic      out_valid,
  input  logic      out_stall,
  output result_t   out_data,
  output obuf_cnt_t count
);

  result_t   ent_r [OBUF_DEPTH];
  obuf_ptr_t wr_ptr_r, wr_ptr_nxt;
  obuf_ptr_t rd_ptr_r, rd_ptr_nxt;
  obuf_cnt_t cnt_r, cnt_nxt;
  logic      pop;

  function automatic obuf_ptr_t ptr_inc(obuf_ptr_t p);
    return (p == obuf_ptr_t'(OBUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + obuf_cnt_t'(push) - obuf_cnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/wireworld_generation_step.sv
// ----------------------------------------------------------------------------
// wireworld_generation_step
// Streaming WireWorld generation step, one grid cell per transaction.
// ----------------------------------------------------------------------------
// Cells enter on the in_ channel in raster order; each accepted transaction
// carries one cell (or a drain filler). The result for raster cell p leaves
// on the out_ channel once cell p + grid_cols + 1 has been accepted, so
// grid_cols + 1 drain transactions follow a frame to flush its last results.
// Rate: one cell per cycle while in_stall is low. A result released by an
// accepted transaction passes the registered line store read, then the
// window and rule stage, into a 3-entry result queue that drives out_.
// The line stores are two single-port-write, one-read memories of MAX_COLS
// entries with a registered read; a write and a read of the same entry in
// the same cycle (one-column grids) is forwarded.
// Reset: counters and window clear at once, then every entry of both line
// stores is swept to empty with in_stall high. APB writes are taken at any
// time; in_stall is held for one cycle after each write.
// A stalled receiver fills the result queue; in_stall rises when the queue
// and the window stage together hold three entries. No result is dropped.
// ----------------------------------------------------------------------------
module wireworld_generation_step import ww_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  // cell input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cell_state,
  input  logic              in_drain,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_next_state,
  output logic              out_head_born,
  output logic              out_frame_end,
  output logic              out_frame_any_born,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int PW   = CCW + RCW;

  function automatic int clamp_reg(logic [REG_W-1:0] v, int max_v);
    if (v == '0) return 1;
    return (32'(v) > max_v) ? max_v : int'(v);
  endfunction

  // ---------------------------------------------------------------- config
  logic [REG_W-1:0] grid_cols_r, grid_rows_r;
  logic [CCW-1:0]   cols_r;
  logic [RCW-1:0]   rows_r;
  logic [PW-1:0]    total_r;
  logic             cfg_hold_r;
  logic             cfg_we;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_GRID_COLS: prdata = CFG_DW'(grid_cols_r);
      REG_GRID_ROWS: prdata = CFG_DW'(grid_rows_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= REG_W'(1024);
      grid_rows_r <= REG_W'(1024);
      cols_r      <= CCW'(clamp_reg(REG_W'(1024), MAX_COLS));
      rows_r      <= RCW'(clamp_reg(REG_W'(1024), MAX_ROWS));
      cfg_hold_r  <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_GRID_COLS: begin
            grid_cols_r <= pwdata[REG_W-1:0];
            cols_r      <= CCW'(clamp_reg(pwdata[REG_W-1:0], MAX_COLS));
          end
          REG_GRID_ROWS: begin
            grid_rows_r <= pwdata[REG_W-1:0];
            rows_r      <= RCW'(clamp_reg(pwdata[REG_W-1:0], MAX_ROWS));
          end
        endcase
      end
    end
  end

  // frame size, registered from the clamped sizes (the in_stall hold after a write covers its update)
  always_ff @(posedge clk) begin
    total_r <= PW'(cols_r) * PW'(rows_r);
  end

  // --------------------------------------------------------- clearing sweep
  mode_t          mode_r, mode_nxt;
  logic [CW-1:0]  clr_addr_r, clr_addr_nxt;

  always_comb begin
    mode_nxt     = mode_r;
    clr_addr_nxt = clr_addr_r;
    unique case (mode_r)
      MODE_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == CW'(MAX_COLS - 1)) begin
          mode_nxt     = MODE_RUN;
          clr_addr_nxt = '0;
        end
      end
      MODE_RUN: mode_nxt = MODE_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CLEAR;
      clr_addr_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ----------------------------------------------------------- accept stage
  logic [CW-1:0]        col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 accept, wrap, emit0, last0;
  stage_ctl_t           ctl0;
  obuf_cnt_t            ob_count;
  logic                 s1_v_r;

  assign in_stall = (mode_r == MODE_CLEAR) || cfg_hold_r
                 || ((3'(ob_count) + 3'(s1_v_r)) >= 3'(OBUF_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    wrap  = (32'(col_r) + 32'd1) >= 32'(cols_r);
    emit0 = (row_r >= ROW_CNT_W'(2)) || (row_r == ROW_CNT_W'(1) && col_r != '0);
    last0 = emit0 && ((32'(pos_r) + 32'd1) >= 32'(total_r));

    ctl0.cur      = (in_drain || 32'(row_r) >= 32'(rows_r)) ? CELL_EMPTY
                                                            : cell_t'(in_cell_state);
    ctl0.row_zero = (row_r == '0);
    ctl0.col_zero = (col_r == '0);
    ctl0.emit     = emit0;
    ctl0.last     = last0;

    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (last0) begin
        col_nxt = '0;
        row_nxt = '0;
        pos_nxt = '0;
      end else begin
        if (wrap) begin
          col_nxt = '0;
          if (row_r != ROW_CNT_W'(ROW_SAT)) row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (emit0) pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

  // ------------------------------------------------------------ line stores
  cell_t         upper_mem  [MAX_COLS];
  cell_t         middle_mem [MAX_COLS];
  cell_t         up_q_r, mid_q_r;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  cell_t         up_wdata, mid_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[mem_waddr]  <= up_wdata;
      middle_mem[mem_waddr] <= mid_wdata;
    end
    if (accept) begin
      up_q_r  <= upper_mem[col_r];
      mid_q_r <= middle_mem[col_r];
    end
  end

  // ----------------------------------------------------------- window stage
  stage_ctl_t    s1_r;
  logic [CW-1:0] s1_addr_r;
  logic          fwd_r;
  cell_t         last_up_r, last_mid_r;
  cell_t         up_eff, mid_eff;
  logic          born_seen_r;
  win_in_t       win_in;
  rule_out_t     rule_out;
  result_t       res;
  logic          push;

  always_comb begin
    // same entry written by the previous cell at our read edge
    up_eff  = fwd_r ? last_up_r  : up_q_r;
    mid_eff = fwd_r ? last_mid_r : mid_q_r;
    if (s1_r.row_zero) begin
      up_eff  = CELL_EMPTY;
      mid_eff = CELL_EMPTY;
    end

    win_in.up       = up_eff;
    win_in.mid      = mid_eff;
    win_in.cur      = s1_r.cur;
    win_in.col_zero = s1_r.col_zero;

    if (mode_r == MODE_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      up_wdata  = CELL_EMPTY;
      mid_wdata = CELL_EMPTY;
    end else begin
      mem_we    = s1_v_r;
      mem_waddr = s1_addr_r;
      up_wdata  = mid_eff;
      mid_wdata = s1_r.cur;
    end

    push               = s1_v_r && s1_r.emit;
    res.next_state     = rule_out.next_state;
    res.head_born      = rule_out.head_born;
    res.frame_end      = s1_r.last;
    res.frame_any_born = s1_r.last && (born_seen_r || rule_out.head_born);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      born_seen_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (push) begin
        born_seen_r <= s1_r.last ? 1'b0 : (born_seen_r || rule_out.head_born);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= ctl0;
      s1_addr_r <= col_r;
      fwd_r     <= s1_v_r && (s1_addr_r == col_r);
    end
    if (s1_v_r) begin
      last_up_r  <= mid_eff;
      last_mid_r <= s1_r.cur;
    end
  end

  ww_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_v_r),
    .win_in   (win_in),
    .rule_out (rule_out)
  );

  // ------------------------------------------------------------ result queue
  result_t out_data;

  ww_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (ob_count)
  );

  assign out_next_state     = out_data.next_state;
  assign out_head_born      = out_data.head_born;
  assign out_frame_end      = out_data.frame_end;
  assign out_frame_any_born = out_data.frame_any_born;

endmodule

>>> verif/wireworld_generation_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wireworld_generation_step_tb
// Self-checking bench for the streaming WireWorld generation step.
// ----------------------------------------------------------------------------
// Grid cells are streamed frame by frame in raster order, each frame followed
// by its flush transactions. A cycle-free model of the line stores and window
// predicts every next-generation cell, which is compared field by field with
// what leaves the out_ channel. A short directed table comes first (single
// cells, zero registers, a small grid, a width change mid-frame), then random
// frames of many small shapes, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module wireworld_generation_step_tb;
  import ww_pkg::*;

  localparam int MAX_COLS    = DEF_MAX_COLS;
  localparam int MAX_ROWS    = DEF_MAX_ROWS;
  localparam int RAND_CELLS  = 600;
  localparam int QUIET_AFTER = 480;
  localparam int SETTLE_CYC  = 8;
  localparam int TAIL_CYC    = 16;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic { STEP_CELL, STEP_CFG } step_kind_t;

  typedef struct {
    step_kind_t       kind;
    reg_idx_t         ridx;
    logic [REG_W-1:0] val;
    cell_t            cell_st;
    logic             drain;
    bit               typed;
    result_t          want;
  } dir_step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_cell_state = '0;
  logic              in_drain = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_next_state;
  logic              out_head_born;
  logic              out_frame_end;
  logic              out_frame_any_born;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // predictor state
  logic [REG_W-1:0] cols_reg;
  logic [REG_W-1:0] rows_reg;
  cell_t            upper_row_mem  [MAX_COLS];
  cell_t            middle_row_mem [MAX_COLS];
  cell_t            nbr_win [3][3];   // [column left..right][row upper..lower]
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int unsigned      out_pos;
  bit               born_seen;

  result_t     next_gen_q [$];
  dir_step_t   dir_steps [$];
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cells_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned births = 0;
  int unsigned born_frames = 0;
  int unsigned reg_writes = 0;

  wireworld_generation_step u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_state      (in_cell_state),
    .in_drain           (in_drain),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_state     (out_next_state),
    .out_head_born      (out_head_born),
    .out_frame_end      (out_frame_end),
    .out_frame_any_born (out_frame_any_born),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               next_gen_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned eff_size(input logic [REG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // One accepted cell through the line stores and the 3x3 window.
  function automatic bit evolve_cell(input logic [1:0] cs, input logic dr, output result_t res);
    int unsigned cols, rows, total, idx;
    cell_t       cur, up, mid, centre, nxt;
    bit          emit, born;
    int          heads;
    cols  = eff_size(cols_reg, MAX_COLS);
    rows  = eff_size(rows_reg, MAX_ROWS);
    total = cols * rows;
    cur   = cell_t'(cs);
    if (dr || row_cnt >= rows) cur = CELL_EMPTY;
    idx = (col_cnt < MAX_COLS) ? col_cnt : MAX_COLS - 1;
    up  = CELL_EMPTY;
    mid = CELL_EMPTY;
    if (row_cnt != 0) begin
      up  = upper_row_mem[idx];
      mid = middle_row_mem[idx];
    end
    emit = (row_cnt >= 2) || (row_cnt == 1 && col_cnt >= 1);
    for (int r = 0; r < 3; r++) begin
      nbr_win[0][r] = nbr_win[1][r];
      nbr_win[1][r] = nbr_win[2][r];
      nbr_win[2][r] = CELL_EMPTY;
    end
    if (col_cnt != 0) begin
      nbr_win[2][0] = up;
      nbr_win[2][1] = mid;
      nbr_win[2][2] = cur;
    end
    centre = nbr_win[1][1];
    nxt    = centre;
    born   = 1'b0;
    case (centre)
      CELL_HEAD: nxt = CELL_TAIL;
      CELL_TAIL: nxt = CELL_COND;
      CELL_COND: begin
        heads = 0;
        for (int c = 0; c < 3; c++)
          for (int r = 0; r < 3; r++)
            if (!(c == 1 && r == 1) && nbr_win[c][r] == CELL_HEAD) heads++;
        if (heads == 1 || heads == 2) begin
          nxt  = CELL_HEAD;
          born = 1'b1;
        end
      end
      default: ;
    endcase
    // left edge of a row: nothing to the left of the new cell
    if (col_cnt == 0) begin
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          nbr_win[c][r] = CELL_EMPTY;
      nbr_win[2][0] = up;
      nbr_win[2][1] = mid;
      nbr_win[2][2] = cur;
    end
    upper_row_mem[idx]  = mid;
    middle_row_mem[idx] = cur;
    if (col_cnt + 1 >= cols) begin
      col_cnt = 0;
      if (row_cnt < ROW_SAT) row_cnt++;
    end else begin
      col_cnt++;
    end
    res = '0;
    if (!emit) return 1'b0;
    res.next_state = nxt;
    res.head_born  = born;
    born_seen      = born_seen | born;
    if (out_pos + 1 >= total) begin
      res.frame_end      = 1'b1;
      res.frame_any_born = born_seen;
      col_cnt   = 0;
      row_cnt   = 0;
      out_pos   = 0;
      born_seen = 1'b0;
    end else begin
      out_pos++;
    end
    return 1'b1;
  endfunction

  function automatic cell_t rand_cell();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return CELL_COND;
    if (r < 12) return CELL_HEAD;
    if (r < 15) return CELL_TAIL;
    return CELL_EMPTY;
  endfunction

  function automatic dir_step_t cell_step(input cell_t c, input logic d);
    dir_step_t s;
    s.kind    = STEP_CELL;
    s.ridx    = REG_GRID_COLS;
    s.val     = '0;
    s.cell_st = c;
    s.drain   = d;
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic dir_step_t known_step(input cell_t c, input logic d, input result_t w);
    dir_step_t s;
    s       = cell_step(c, d);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  function automatic dir_step_t reg_step(input reg_idx_t i, input logic [REG_W-1:0] v);
    dir_step_t s;
    s      = cell_step(CELL_EMPTY, 1'b0);
    s.kind = STEP_CFG;
    s.ridx = i;
    s.val  = v;
    return s;
  endfunction

  task automatic read_reg(input reg_idx_t ridx, output logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(4 * int'(ridx));
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write, then read back
  task automatic program_reg(input reg_idx_t ridx, input logic [REG_W-1:0] val);
    logic [CFG_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(ridx));
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (ridx == REG_GRID_COLS) cols_reg = val;
    else rows_reg = val;
    reg_writes++;
    @(posedge clk);
    read_reg(ridx, rd);
    if (rd[REG_W-1:0] !== val)
      flag_mismatch($sformatf("register %s reads %0d, written %0d", ridx.name(),
                              rd[REG_W-1:0], val));
  endtask

  // sender holds off until every predicted cell has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic send_cell(input logic [1:0] cs, input logic dr, input bit typed,
                           input result_t want);
    result_t got;
    bit      has;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_state <= cs;
    in_drain      <= dr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    has = evolve_cell(cs, dr, got);
    if (has) next_gen_q.push_back(typed ? want : got);
    cells_sent++;
  endtask

  // one frame of random cells plus its flush transactions
  task automatic run_frame();
    int unsigned cols, rows;
    cols = eff_size(cols_reg, MAX_COLS);
    rows = eff_size(rows_reg, MAX_ROWS);
    for (int unsigned i = 0; i < cols * rows; i++)
      send_cell(rand_cell(), ($urandom_range(0, 31) == 0), 1'b0, '0);
    for (int unsigned i = 0; i <= cols; i++)
      send_cell(rand_cell(), ($urandom_range(0, 3) != 0), 1'b0, '0);
  endtask

  task automatic check_result();
    result_t want;
    if (next_gen_q.size() == 0) begin
      flag_mismatch("result transaction with nothing expected");
      return;
    end
    want = next_gen_q.pop_front();
    if (out_next_state !== want.next_state)
      flag_mismatch($sformatf("result %0d: next_state %0d, expected %0d", results_seen,
                              out_next_state, want.next_state));
    if (out_head_born !== want.head_born)
      flag_mismatch($sformatf("result %0d: head_born %b, expected %b", results_seen,
                              out_head_born, want.head_born));
    if (out_frame_end !== want.frame_end)
      flag_mismatch($sformatf("result %0d: frame_end %b, expected %b", results_seen,
                              out_frame_end, want.frame_end));
    if (out_frame_any_born !== want.frame_any_born)
      flag_mismatch($sformatf("result %0d: frame_any_born %b, expected %b", results_seen,
                              out_frame_any_born, want.frame_any_born));
    results_seen++;
    if (want.head_born) births++;
    if (want.frame_end) begin
      frames_done++;
      if (want.frame_any_born) born_frames++;
    end
  endtask

  // result monitor and receiver stall bursts
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) check_result();
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 9);
    out_stall <= (stall_left > 0);
  end

  initial begin
    logic [CFG_DW-1:0] rd;
    logic [REG_W-1:0]  c_val, r_val;
    int unsigned       frame_no, sent_prev, small_cells;
    bit                new_shape;
    dir_step_t         s;

    cols_reg  = 11'd1024;
    rows_reg  = 11'd1024;
    col_cnt   = 0;
    row_cnt   = 0;
    out_pos   = 0;
    born_seen = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) begin
      upper_row_mem[i]  = CELL_EMPTY;
      middle_row_mem[i] = CELL_EMPTY;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        nbr_win[c][r] = CELL_EMPTY;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    read_reg(REG_GRID_COLS, rd);
    if (rd[REG_W-1:0] !== 11'd1024)
      flag_mismatch($sformatf("grid_cols after reset reads %0d", rd[REG_W-1:0]));
    read_reg(REG_GRID_ROWS, rd);
    if (rd[REG_W-1:0] !== 11'd1024)
      flag_mismatch($sformatf("grid_rows after reset reads %0d", rd[REG_W-1:0]));

    // single-cell grid: a lone head turns into a tail
    dir_steps.push_back(reg_step(REG_GRID_COLS, 11'd1));
    dir_steps.push_back(reg_step(REG_GRID_ROWS, 11'd1));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b0));
    dir_steps.push_back(cell_step(CELL_EMPTY, 1'b1));
    dir_steps.push_back(known_step(CELL_EMPTY, 1'b1, result_t'{CELL_TAIL, 1'b0, 1'b1, 1'b0}));
    // zero registers act as one; a lone conductor stays put
    dir_steps.push_back(reg_step(REG_GRID_COLS, 11'd0));
    dir_steps.push_back(reg_step(REG_GRID_ROWS, 11'd0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_TAIL, 1'b1));
    dir_steps.push_back(known_step(CELL_HEAD, 1'b1, result_t'{CELL_COND, 1'b0, 1'b1, 1'b0}));
    // 3x2 grid: drain inside the frame, live cell among the flush
    dir_steps.push_back(reg_step(REG_GRID_COLS, 11'd3));
    dir_steps.push_back(reg_step(REG_GRID_ROWS, 11'd2));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b1));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_TAIL, 1'b0));
    dir_steps.push_back(cell_step(CELL_EMPTY, 1'b1));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_EMPTY, 1'b1));
    dir_steps.push_back(cell_step(CELL_EMPTY, 1'b1));
    // 4x2 grid narrowed to 2 columns partway through the second row
    dir_steps.push_back(reg_step(REG_GRID_COLS, 11'd4));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_TAIL, 1'b0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b0));
    dir_steps.push_back(reg_step(REG_GRID_COLS, 11'd2));
    dir_steps.push_back(cell_step(CELL_HEAD, 1'b0));
    dir_steps.push_back(cell_step(CELL_COND, 1'b0));
    dir_steps.push_back(cell_step(CELL_EMPTY, 1'b1));

    foreach (dir_steps[i]) begin
      s = dir_steps[i];
      if (s.kind == STEP_CFG) begin
        wait_drained();
        program_reg(s.ridx, s.val);
      end else begin
        send_cell(s.cell_st, s.drain, s.typed, s.want);
      end
    end

    // oversize register values read back as written
    wait_drained();
    program_reg(REG_GRID_COLS, 11'd2047);
    program_reg(REG_GRID_ROWS, 11'd1025);

    frame_no    = 0;
    small_cells = 0;
    while (small_cells < RAND_CELLS) begin
      new_shape = (frame_no == 0) || ($urandom_range(0, 2) == 0);
      c_val = ($urandom_range(0, 9) == 0) ? 11'd0 : REG_W'($urandom_range(1, 12));
      r_val = ($urandom_range(0, 9) == 0) ? 11'd1 : REG_W'($urandom_range(1, 9));
      if (new_shape) begin
        wait_drained();
        program_reg(REG_GRID_COLS, c_val);
        program_reg(REG_GRID_ROWS, r_val);
      end
      quiet     = (small_cells >= QUIET_AFTER);
      sent_prev = cells_sent;
      run_frame();
      small_cells += cells_sent - sent_prev;
      frame_no++;
    end

    in_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("run covered %0d cells over %0d frames (1x1 up to 12x9, zero and oversize regs)",
             cells_sent, frames_done);
    $display("%0d results checked, %0d heads born, %0d frames with births, %0d reg writes",
             results_seen, births, born_frames, reg_writes);
    if (mismatch_cnt == 0 && next_gen_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
